[sv/olr_pkg.sv]
// Shared types and constants of the oriented line rasterizer.
package olr_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int DVD_W       = 16;
    localparam int DVS_W       = 8;

    // Command codes.
    localparam logic [1:0] MODE_LINE   = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ORIENT = 2'd2;
    localparam logic [1:0] CFG_INVERT = 2'd3;

    // Orientation codes.
    localparam logic [1:0] ORI_LAND      = 2'd0;
    localparam logic [1:0] ORI_PORT      = 2'd1;
    localparam logic [1:0] ORI_LAND_INV  = 2'd2;
    localparam logic [1:0] ORI_PORT_INV  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DVD_W-1:0]  quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

[sv/olr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module olr_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  olr_pkg::div_req_t req,
    output olr_pkg::div_rsp_t rsp
);
    import olr_pkg::*;

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    // Shift in the next dividend bit and trial-subtract the divisor.
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W])
            begin
                rem_reg <= diff[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

[sv/olr_store.sv]
// Frame store: one write port and one registered read port.
module olr_store
(
    input  logic                        clk,
    input  olr_pkg::mem_wr_t            wr,
    input  logic [olr_pkg::ADDR_W-1:0]  raddr,
    output logic [7:0]                  rdata
);
    import olr_pkg::*;

    logic [7:0] mem [STORE_DEPTH];

    // Write and read the byte array.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/oriented_line_rasterizer.sv]
// Top level of the oriented line rasterizer: sequencer, plot datapath and output register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_ready | mode, start_x, start_y, end_x, end_y, byte_addr
//  out      | out_valid/out_ready | status, read_data
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// A read passes S_RDWAIT and S_RDDATA (neither when out of range); a clear writes every store byte, one byte per cycle.
// A line takes per column a multiply and a run of the 16-step shared divider,
// plus a read-modify-write for each on-screen pixel; off-screen pixels skip the store.
// The frame store is not cleared by reset; its contents are undefined until a clear command.
// One command is in flight at a time; in_ready is high only while the sequencer is idle,
// and a finished result waits in the output register while out_ready is low.
module oriented_line_rasterizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  start_x,
    input  logic [7:0]  start_y,
    input  logic [7:0]  end_x,
    input  logic [7:0]  end_y,
    input  logic [9:0]  byte_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [7:0]  read_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import olr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLEAR  = 13'b0000000000010,
        S_RDWAIT = 13'b0000000000100,
        S_RDDATA = 13'b0000000001000,
        S_LSETUP = 13'b0000000010000,
        S_MUL    = 13'b0000000100000,
        S_DSTART = 13'b0000001000000,
        S_DIV    = 13'b0000010000000,
        S_MAP    = 13'b0000100000000,
        S_PRD    = 13'b0001000000000,
        S_PWR    = 13'b0010000000000,
        S_PNEXT  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic [1:0] orient_reg;
    logic       invert_reg;

    logic [7:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic       vert_reg, neg_reg;
    logic [7:0] fx_reg, lx_reg, fy_reg, ly_reg;
    logic [7:0] x_reg, ycur_reg, hi_reg, ny_reg, cnt_reg, f_reg, t_reg;
    logic signed [18:0] prod_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [7:0] bit_reg;
    logic       st_reg;
    logic [7:0] data_reg;
    logic       out_valid_reg, status_reg;
    logic [7:0] read_data_reg;

    logic [7:0]  w_eff, wm1, hm1;
    logic [6:0]  h_eff;
    logic [8:0]  w_round;
    logic [4:0]  rb;
    logic [11:0] read_lim;
    logic [7:0]  ysum, plot_y, nx, ny;
    logic        oob;
    logic [5:0]  row;
    logic [10:0] row_off;
    logic [ADDR_W-1:0] idx;
    logic [7:0]  xp;
    logic signed [9:0]  dx_s;
    logic signed [8:0]  dy_s;
    logic        prod_neg;
    logic [18:0] prod_mag;
    logic [7:0]  q_low, q_s, ny_v, dd;
    logic [7:0]  rdata;
    logic [7:0]  bg;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mem_wr_t  mem_wr;

    olr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    olr_store u_store
    (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // Effective display size and row pitch.
    always_comb
    begin
        if (width_reg == 8'd0)
            w_eff = 8'd1;
        else if (width_reg > 8'(MAX_WIDTH))
            w_eff = 8'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 7'd0)
            h_eff = 7'd1;
        else if (height_reg > 7'(MAX_HEIGHT))
            h_eff = 7'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign wm1      = w_eff - 8'd1;
    assign hm1      = {1'b0, h_eff} - 8'd1;
    assign w_round  = {1'b0, w_eff} + 9'd7;
    assign rb       = w_round[7:3];
    assign read_lim = 12'(rb * h_eff);
    assign bg       = invert_reg ? 8'hff : 8'h00;

    // Candidate y of the current pixel, with negative values clamped to zero.
    assign ysum   = neg_reg ? (ycur_reg - f_reg) : (ycur_reg + f_reg);
    assign plot_y = vert_reg ? ycur_reg : (ysum[7] ? 8'd0 : ysum);

    // Orientation mapping and bounds check.
    always_comb
    begin
        case (orient_reg)
            ORI_PORT:
            begin
                nx = wm1 - plot_y;
                ny = x_reg;
            end
            ORI_LAND_INV:
            begin
                nx = wm1 - x_reg;
                ny = hm1 - plot_y;
            end
            ORI_PORT_INV:
            begin
                nx = plot_y;
                ny = hm1 - x_reg;
            end
            default:
            begin
                nx = x_reg;
                ny = plot_y;
            end
        endcase
    end

    assign oob     = (nx > wm1) || (ny > hm1);
    assign row     = 6'(hm1 - ny);
    assign row_off = 11'(rb * row);
    assign idx     = ADDR_W'(row_off + {6'd0, nx[7:3]});

    // Interpolation numerator for the next column.
    assign xp       = x_reg + 8'd1;
    assign dx_s     = signed'({2'b00, xp} - {2'b00, fx_reg});
    assign dy_s     = signed'({1'b0, ly_reg} - {1'b0, fy_reg});
    assign prod_neg = prod_reg[18];
    assign prod_mag = prod_neg ? (19'd0 - prod_reg) : prod_reg;

    // Signed quotient low byte, next column y and pixel count of this column.
    assign q_low = div_rsp.quotient[7:0];
    assign q_s   = prod_neg ? (8'd0 - q_low) : q_low;
    assign ny_v  = q_s + fy_reg;
    assign dd    = ycur_reg - ny_v;

    assign div_req.start    = (state_reg == S_DSTART);
    assign div_req.dividend = prod_mag[DVD_W-1:0];
    assign div_req.divisor  = lx_reg - fx_reg;

    // Store writes: clear sweep or the write half of a pixel update.
    always_comb
    begin
        mem_wr.en   = (state_reg == S_CLEAR) || (state_reg == S_PWR);
        mem_wr.addr = addr_reg;
        if (state_reg == S_CLEAR)
            mem_wr.data = bg;
        else if (invert_reg)
            mem_wr.data = rdata & ~bit_reg;
        else
            mem_wr.data = rdata | bit_reg;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_LINE:  state_next = S_LSETUP;
                        MODE_READ:
                        begin
                            if ({2'b00, byte_addr} < read_lim)
                                state_next = S_RDWAIT;
                            else
                                state_next = S_DONE;
                        end
                        MODE_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                    state_next = S_DONE;
            end
            S_RDWAIT: state_next = S_RDDATA;
            S_RDDATA: state_next = S_DONE;
            S_LSETUP: state_next = (ax_reg == bx_reg) ? S_MAP : S_MUL;
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_MAP;
            end
            S_MAP:    state_next = oob ? S_PNEXT : S_PRD;
            S_PRD:    state_next = S_PWR;
            S_PWR:    state_next = S_PNEXT;
            S_PNEXT:
            begin
                if (vert_reg)
                begin
                    state_next = (ycur_reg == hi_reg) ? S_DONE : S_MAP;
                end
                else if ((t_reg == ly_reg) && (fy_reg != ly_reg))
                begin
                    state_next = S_DONE;
                end
                else if ((f_reg + 8'd1) < cnt_reg)
                begin
                    state_next = S_MAP;
                end
                else
                begin
                    state_next = (x_reg == lx_reg) ? S_DONE : S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 8'd128;
            height_reg    <= 7'd64;
            orient_reg    <= ORI_LAND;
            invert_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data[6:0];
                    CFG_ORIENT: orient_reg <= cfg_data[1:0];
                    CFG_INVERT: invert_reg <= cfg_data[0];
                    default:    width_reg  <= width_reg;
                endcase
            end
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ax_reg   <= start_x;
                ay_reg   <= start_y;
                bx_reg   <= end_x;
                by_reg   <= end_y;
                addr_reg <= (mode == MODE_READ) ? byte_addr : '0;
                st_reg   <= (mode == MODE_READ) && !({2'b00, byte_addr} < read_lim);
                data_reg <= 8'd0;
            end
            S_CLEAR:  addr_reg <= addr_reg + ADDR_W'(1);
            S_RDDATA: data_reg <= rdata;
            S_LSETUP:
            begin
                f_reg <= 8'd0;
                if (ax_reg == bx_reg)
                begin
                    vert_reg <= 1'b1;
                    x_reg    <= ax_reg;
                    ycur_reg <= (ay_reg < by_reg) ? ay_reg : by_reg;
                    hi_reg   <= (ay_reg < by_reg) ? by_reg : ay_reg;
                end
                else
                begin
                    vert_reg <= 1'b0;
                    if (ax_reg > bx_reg)
                    begin
                        fx_reg   <= bx_reg;
                        lx_reg   <= ax_reg;
                        fy_reg   <= by_reg;
                        ly_reg   <= ay_reg;
                        x_reg    <= bx_reg;
                        ycur_reg <= by_reg;
                        neg_reg  <= by_reg > ay_reg;
                    end
                    else
                    begin
                        fx_reg   <= ax_reg;
                        lx_reg   <= bx_reg;
                        fy_reg   <= ay_reg;
                        ly_reg   <= by_reg;
                        x_reg    <= ax_reg;
                        ycur_reg <= ay_reg;
                        neg_reg  <= ay_reg > by_reg;
                    end
                end
            end
            S_MUL:    prod_reg <= dx_s * dy_s;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    ny_reg  <= ny_v;
                    cnt_reg <= dd[7] ? (8'd0 - dd) : dd;
                    f_reg   <= 8'd0;
                end
            end
            S_MAP:
            begin
                st_reg   <= oob;
                t_reg    <= plot_y;
                addr_reg <= idx;
                bit_reg  <= 8'h80 >> nx[2:0];
            end
            S_PNEXT:
            begin
                if (vert_reg)
                begin
                    ycur_reg <= ycur_reg + 8'd1;
                end
                else if ((f_reg + 8'd1) < cnt_reg)
                begin
                    f_reg <= f_reg + 8'd1;
                end
                else
                begin
                    x_reg    <= x_reg + 8'd1;
                    ycur_reg <= ny_reg;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    status_reg    <= st_reg;
                    read_data_reg <= data_reg;
                end
            end
            default: x_reg <= x_reg;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_data = read_data_reg;

    // The store is never written while the sequencer waits for a command.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_wr.en)
        else $error("store written while idle");

    // A finished result holds the sequencer until the output register frees.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwritten before it was taken");

    // An accepted command drops ready on the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second command accepted while busy");

    // The pixel counter of a column is zero or stays below its count.
    a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAP && !vert_reg) |-> (f_reg == 8'd0 || f_reg < cnt_reg))
        else $error("column pixel counter overran");

    // The divider is started only when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule
